/* sv/rrbm_pkg.sv */
// Shared types and constants for the cartridge ROM/RAM bank mapper.
package rrbm_pkg;

  localparam int unsigned BankBytes   = 16384;
  localparam int unsigned MaxRomBanks = 128;
  localparam int unsigned OffsetW     = $clog2(BankBytes);
  localparam int unsigned BankW       = $clog2(MaxRomBanks);
  localparam int unsigned MemAddrW    = 21;
  localparam int unsigned BusAddrW    = 16;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned CfgIndexW   = 2;

  localparam logic [4:0] LowBankMask   = 5'h1F;
  localparam logic [3:0] RamEnableCode = 4'hA;
  localparam logic [4:0] LowBankReset  = 5'd1;
  localparam logic [7:0] RomCountReset = 8'd2;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CART_KIND = 2'd0,
    CFG_ROM_BANKS = 2'd1,
    CFG_RAM_BANKS = 2'd2
  } cfg_index_e;

  // Mapper register select, bus address bits 14:13 below 0x8000.
  typedef enum logic [1:0] {
    REG_RAM_ENABLE = 2'd0,
    REG_LOW_BANK   = 2'd1,
    REG_HIGH_BANK  = 2'd2,
    REG_MODE       = 2'd3
  } reg_sel_e;

  typedef struct packed {
    logic       cart_kind;
    logic [7:0] rom_bank_count;
    logic [4:0] ram_bank_count;
  } cfg_t;

  typedef struct packed {
    logic                is_write;
    logic [BusAddrW-1:0] addr;
    logic [7:0]          data;
  } access_t;

  typedef struct packed {
    target_e             target;
    logic [MemAddrW-1:0] mem_address;
    logic                ram_write;
    logic [7:0]          ram_data;
  } result_t;

endpackage

/* sv/rom_ram_bank_mapper.sv */
// Cartridge ROM/RAM bank mapper top level.
// Sits on the processor bus and translates one access per word.
// Input channel (in_valid_i / in_stall_o): operation, bus address, write data.
// Output channel (out_valid_o / out_stall_i): target, physical address, RAM
// write strobe and data. Every input word gives exactly one output word.
// A word is taken at an edge with valid high and stall low.
// An accepted word is held in the input register, passes the translation
// logic and is loaded into the result register when that register has room.
// Throughput: one word per cycle unless the receiver stalls; the input and
// result registers let a new word in while a finished one waits to be taken.
// When the receiver stalls, the result holds; the input register then fills
// and in_stall_o rises until the result leaves.
// Mapper registers (RAM enable, low/high bank, mode) change as a write word
// moves into the result register, so later words see the new mapping.
// Reset clears both registers' valid flags, sets RAM disabled, low bank 1,
// high bank 0, simple mode, configuration to bank controller, two ROM banks,
// no RAM. User writes configuration (cfg_we_i) only while idle; unenforced.
module rom_ram_bank_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrbm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rrbm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [15:0]                    bus_address_i,
  input  logic [7:0]                     write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     target_o,
  output logic [20:0]                    mem_address_o,
  output logic                           ram_write_o,
  output logic [7:0]                     ram_data_o
);
  import rrbm_pkg::*;

  cfg_t    cfg_q;
  access_t in_access;
  access_t s1_access;
  logic    s1_valid;
  logic    out_room;
  logic    s1_advance;
  result_t map_result;
  result_t out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cart_kind      <= 1'b1;
      cfg_q.rom_bank_count <= RomCountReset;
      cfg_q.ram_bank_count <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_CART_KIND: cfg_q.cart_kind      <= cfg_data_i[0];
        CFG_ROM_BANKS: cfg_q.rom_bank_count <= cfg_data_i;
        CFG_RAM_BANKS: cfg_q.ram_bank_count <= cfg_data_i[4:0];
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  assign in_access.is_write = operation_i;
  assign in_access.addr     = bus_address_i;
  assign in_access.data     = write_data_i;

  assign s1_advance = s1_valid && out_room;

  rrbm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .advance_i  (s1_advance),
    .access_i   (in_access),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .access_o   (s1_access)
  );

  rrbm_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .update_i (s1_advance),
    .access_i (s1_access),
    .result_o (map_result)
  );

  rrbm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_advance),
    .result_i    (map_result),
    .out_stall_i (out_stall_i),
    .advance_o   (out_room),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign target_o      = out_result.target;
  assign mem_address_o = out_result.mem_address;
  assign ram_write_o   = out_result.ram_write;
  assign ram_data_o    = out_result.ram_data;

endmodule

/* sv/rrbm_in_stage.sv */
// Input register of the bank mapper: holds one accepted bus access.
module rrbm_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            advance_i,
  input  rrbm_pkg::access_t access_i,
  output logic            in_stall_o,
  output logic            valid_o,
  output rrbm_pkg::access_t access_o
);
  import rrbm_pkg::*;

  logic    valid_q, valid_d;
  access_t access_q;
  logic    load;

  // Stall only while a held word cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      access_q <= access_i;
    end
  end

  assign valid_o  = valid_q;
  assign access_o = access_q;

endmodule

/* sv/rrbm_map.sv */
// Mapper registers and address translation for one bus access.
module rrbm_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrbm_pkg::cfg_t    cfg_i,
  input  logic              update_i,
  input  rrbm_pkg::access_t access_i,
  output rrbm_pkg::result_t result_o
);
  import rrbm_pkg::*;

  logic             ram_enabled_q, ram_enabled_d;
  logic [4:0]       low_bank_q, low_bank_d;
  logic [1:0]       high_bank_q, high_bank_d;
  logic             mode_q, mode_d;

  logic             has_ram;
  logic             in_ram_window;
  logic [BankW-1:0] bank_mask;
  logic [BankW-1:0] bank;
  logic [4:0]       low_wr;
  reg_sel_e         reg_sel;

  assign has_ram       = cfg_i.ram_bank_count != 5'd0;
  assign in_ram_window = access_i.addr[15:13] == 3'b101;
  assign bank_mask     = BankW'(cfg_i.rom_bank_count - 8'd1);
  assign reg_sel       = reg_sel_e'(access_i.addr[14:13]);
  assign low_wr        = access_i.data[4:0] & LowBankMask;

  // Fixed region takes the high bank only in mode 1.
  always_comb begin
    if (access_i.addr[14]) begin
      bank = {high_bank_q, low_bank_q};
    end else if (mode_q) begin
      bank = {high_bank_q, 5'd0};
    end else begin
      bank = '0;
    end
  end

  always_comb begin
    result_o             = '0;
    result_o.target      = TGT_NONE;
    ram_enabled_d        = ram_enabled_q;
    low_bank_d           = low_bank_q;
    high_bank_d          = high_bank_q;
    mode_d               = mode_q;
    if (!cfg_i.cart_kind) begin
      if (!access_i.is_write && !access_i.addr[15]) begin
        result_o.target      = TGT_ROM;
        result_o.mem_address = MemAddrW'(access_i.addr);
      end
    end else if (!access_i.addr[15]) begin
      if (access_i.is_write) begin
        unique case (reg_sel)
          REG_RAM_ENABLE: ram_enabled_d = (access_i.data[3:0] == RamEnableCode) && has_ram;
          REG_LOW_BANK:   low_bank_d    = (low_wr == 5'd0) ? LowBankReset : low_wr;
          REG_HIGH_BANK:  high_bank_d   = access_i.data[1:0];
          REG_MODE:       mode_d        = access_i.data[0];
          default:        mode_d        = mode_q;
        endcase
      end else begin
        result_o.target      = TGT_ROM;
        result_o.mem_address = MemAddrW'({bank & bank_mask, access_i.addr[OffsetW-1:0]});
      end
    end else if (in_ram_window && ram_enabled_q && has_ram) begin
      // Drop RAM writes in mode 1: only bank 0 of RAM is mapped.
      if (!access_i.is_write || !mode_q) begin
        result_o.target      = TGT_RAM;
        result_o.mem_address = MemAddrW'(access_i.addr[12:0]);
        result_o.ram_write   = access_i.is_write;
        result_o.ram_data    = access_i.is_write ? access_i.data : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_enabled_q <= 1'b0;
      low_bank_q    <= LowBankReset;
      high_bank_q   <= 2'd0;
      mode_q        <= 1'b0;
    end else if (update_i) begin
      ram_enabled_q <= ram_enabled_d;
      low_bank_q    <= low_bank_d;
      high_bank_q   <= high_bank_d;
      mode_q        <= mode_d;
    end
  end

endmodule

/* sv/rrbm_out_stage.sv */
// Result register of the bank mapper.
module rrbm_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rrbm_pkg::result_t result_i,
  input  logic              out_stall_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output rrbm_pkg::result_t result_o
);
  import rrbm_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Room when empty or when the held word leaves this cycle.
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* tb/sv/rom_ram_bank_mapper_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the cartridge bank mapper: directed table, then random bus traffic.
module rom_ram_bank_mapper_test;
  import rrbm_pkg::*;

  localparam logic       OP_READ    = 1'b0;
  localparam logic       OP_WRITE   = 1'b1;
  localparam logic [2:0] RamWindow  = 3'b101;  // 0xA000-0xBFFF
  localparam int         WatchLimit = 4000;
  localparam int         PhaseWords = 192;
  localparam int         NumPhases  = 8;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i   = 1'b0;
  logic [15:0]          bus_address_i = '0;
  logic [7:0]           write_data_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           target_o;
  logic [20:0]          mem_address_o;
  logic                 ram_write_o;
  logic [7:0]           ram_data_o;

  rom_ram_bank_mapper DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .bus_address_i(bus_address_i),
    .write_data_i(write_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .target_o(target_o),
    .mem_address_o(mem_address_o),
    .ram_write_o(ram_write_o),
    .ram_data_o(ram_data_o)
  );

  // Mapper copy: configuration and bank registers, at their reset values.
  logic       cart_is_mbc = 1'b1;
  logic [7:0] rom_banks   = RomCountReset;
  logic [4:0] ram_banks   = 5'd0;
  logic       ram_on      = 1'b0;
  logic [4:0] low_bank    = LowBankReset;
  logic [1:0] high_bank   = 2'd0;
  logic       bank_mode   = 1'b0;

  result_t expected_words[$];
  int      mismatches     = 0;
  int      quiet_cycles   = 0;
  int      stall_hold     = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  typedef struct {
    bit          is_cfg;
    cfg_index_e  idx;
    logic [7:0]  cfg_val;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          has_exp;
    target_e     tgt;
    logic [20:0] maddr;
    logic        wr;
    logic [7:0]  wdata;
  } dir_row_t;

  dir_row_t dir_table [32] = '{
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h0000, 8'h00, 1'b1, TGT_ROM,  21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h7FFF, 8'h00, 1'b1, TGT_ROM,  21'h007FFF, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'hA000, 8'h00, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h0000, 8'h0A, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'hA000, 8'hFF, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'hFFFF, 8'h00, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_ROM_BANKS, 8'h80, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_RAM_BANKS, 8'h04, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h2000, 8'h00, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h4000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h5FFF, 8'h03, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h7FFF, 8'h00, 1'b1, TGT_ROM,  21'h1FFFFF, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h6000, 8'h01, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h3FFF, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h0000, 8'h0A, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'hBFFF, 8'h00, 1'b1, TGT_RAM,  21'h001FFF, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'hA000, 8'h55, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h7FFF, 8'hFE, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'hA123, 8'hAA, 1'b1, TGT_RAM,  21'h000123, 1'b1, 8'hAA},
    '{1'b1, CFG_ROM_BANKS, 8'h00, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h7FFF, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_ROM_BANKS, 8'h06, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h4000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_CART_KIND, 8'h00, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'h7FFF, 8'h00, 1'b1, TGT_ROM,  21'h007FFF, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_WRITE, 16'h2000, 8'h05, 1'b1, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b0, CFG_CART_KIND, 8'h00, OP_READ,  16'hA000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_CART_KIND, 8'h01, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_ROM_BANKS, 8'h02, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00},
    '{1'b1, CFG_RAM_BANKS, 8'h00, OP_READ,  16'h0000, 8'h00, 1'b0, TGT_NONE, 21'h000000, 1'b0, 8'h00}
  };

  logic       cart_pick [NumPhases] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  logic [7:0] rom_pick  [NumPhases] = '{8'd2, 8'd128, 8'd4, 8'd0, 8'd32, 8'd16, 8'd6, 8'd255};
  logic [4:0] ram_pick  [NumPhases] = '{5'd1, 5'd16, 5'd0, 5'd4, 5'd16, 5'd2, 5'd31, 5'd8};

  // Translate one bus access and apply any mapper register write it carries.
  function automatic result_t map_access(logic op, logic [15:0] addr, logic [7:0] data);
    result_t    res;
    logic [7:0] mask8;
    logic [6:0] bank;
    res.target      = TGT_NONE;
    res.mem_address = '0;
    res.ram_write   = 1'b0;
    res.ram_data    = '0;
    mask8 = rom_banks - 8'd1;
    if (!cart_is_mbc) begin
      if (op == OP_READ && !addr[15]) begin
        res.target      = TGT_ROM;
        res.mem_address = MemAddrW'(addr);
      end
    end else if (!addr[15]) begin
      if (op == OP_WRITE) begin
        case (reg_sel_e'(addr[14:13]))
          REG_RAM_ENABLE: ram_on = (data[3:0] == RamEnableCode) && (ram_banks != 5'd0);
          REG_LOW_BANK: begin
            low_bank = data[4:0] & LowBankMask;
            if (low_bank == 5'd0) low_bank = 5'd1;
          end
          REG_HIGH_BANK: high_bank = data[1:0];
          default: bank_mode = data[0];
        endcase
      end else begin
        // Fixed region takes the high bank only in mode 1.
        bank = addr[14] ? {high_bank, low_bank} : (bank_mode ? {high_bank, 5'd0} : 7'd0);
        res.target      = TGT_ROM;
        res.mem_address = {bank & mask8[6:0], addr[13:0]};
      end
    end else if (addr[15:13] == RamWindow && ram_on && ram_banks != 5'd0) begin
      // Drop RAM writes in mode 1.
      if (op == OP_READ || !bank_mode) begin
        res.target      = TGT_RAM;
        res.mem_address = MemAddrW'(addr[12:0]);
        if (op == OP_WRITE) begin
          res.ram_write = 1'b1;
          res.ram_data  = data;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_access(logic op, logic [15:0] addr, logic [7:0] data, bit fixed,
                             result_t fixed_word);
    result_t predicted;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    bus_address_i <= addr;
    write_data_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    predicted = map_access(op, addr, data);
    expected_words.push_back(fixed ? fixed_word : predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_register(cfg_index_e idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CART_KIND: cart_is_mbc = val[0];
      CFG_ROM_BANKS: rom_banks = val;
      CFG_RAM_BANKS: ram_banks = val[4:0];
      default: ;
    endcase
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        out_stall_i <= 1'b1;
        stall_hold--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unrequested word, target", TGT_NONE, target_o);
      end else begin
        want = expected_words.pop_front();
        if (want.target !== target_o) report_mismatch("target", want.target, target_o);
        if (want.mem_address !== mem_address_o)
          report_mismatch("mem_address", want.mem_address, mem_address_o);
        if (want.ram_write !== ram_write_o)
          report_mismatch("ram_write", want.ram_write, ram_write_o);
        if (want.ram_data !== ram_data_o)
          report_mismatch("ram_data", want.ram_data, ram_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    result_t     typed;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        op;
    int          pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[r]) begin
      if (dir_table[r].is_cfg) begin
        drain_results();
        write_register(dir_table[r].idx, dir_table[r].cfg_val);
      end else begin
        typed.target      = dir_table[r].tgt;
        typed.mem_address = dir_table[r].maddr;
        typed.ram_write   = dir_table[r].wr;
        typed.ram_data    = dir_table[r].wdata;
        send_access(dir_table[r].op, dir_table[r].addr, dir_table[r].data,
                    dir_table[r].has_exp, typed);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_register(CFG_CART_KIND, {7'd0, cart_pick[p]});
      write_register(CFG_ROM_BANKS, rom_pick[p]);
      write_register(CFG_RAM_BANKS, {3'd0, ram_pick[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int k = 0; k < PhaseWords; k++) begin
        // Back up the output so the input side has to stall.
        if (p == 0 && k == 40) stall_hold = 80;
        if (p == 1 && k == 100) drain_results();
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        op   = OP_READ;
        if (pick < 15) begin
          op   = OP_WRITE;
          addr = 16'($urandom_range(0, 16'h7FFF));
          if (addr[14:13] == REG_RAM_ENABLE && $urandom_range(0, 1) == 1)
            data[3:0] = RamEnableCode;
        end else if (pick < 55) begin
          addr = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 80) begin
          op   = 1'($urandom);
          addr = {RamWindow, 13'($urandom)};
        end else begin
          op   = 1'($urandom);
          addr = 16'($urandom);
        end
        send_access(op, addr, data, 1'b0, typed);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
